// ===== hw/rtl/scls_pkg.sv =====
// ----------------------------------------------------------------------------
// scls_pkg
// Shared types, register indexes and reset constants of the sensor channel
// led status block.
// ----------------------------------------------------------------------------
package scls_pkg;

  localparam int unsigned NumChannels = 16;

  localparam int unsigned ChanW  = 4;
  localparam int unsigned AdcW   = 12;
  localparam int unsigned TempW  = 16;
  localparam int unsigned CntW   = 5;
  localparam int unsigned PhaseW = 5;
  localparam int unsigned CfgAddrW = 3;
  localparam int unsigned CfgDataW = 12;

  localparam logic [CfgAddrW-1:0] CFG_OPEN_LEVEL      = 3'd0;
  localparam logic [CfgAddrW-1:0] CFG_SHORT_LEVEL     = 3'd1;
  localparam logic [CfgAddrW-1:0] CFG_DEBOUNCE_LIMIT  = 3'd2;
  localparam logic [CfgAddrW-1:0] CFG_SLOW_BLINK_HALF = 3'd3;
  localparam logic [CfgAddrW-1:0] CFG_PHASE_LAST      = 3'd4;

  localparam logic [11:0] OpenLevelRst     = 12'd3500;
  localparam logic [11:0] ShortLevelRst    = 12'd10;
  localparam logic [3:0]  DebounceLimitRst = 4'd3;
  localparam logic [3:0]  SlowBlinkHalfRst = 4'd10;
  localparam logic [4:0]  PhaseLastRst     = 5'd20;

  localparam logic [CntW-1:0] CntMax = 5'd31;

  typedef enum logic [1:0] {
    MODE_NORMAL = 2'd0,
    MODE_OPEN   = 2'd1,
    MODE_SHORT  = 2'd2,
    MODE_OVER   = 2'd3
  } mode_e;

  typedef struct packed {
    logic [11:0] open_level;
    logic [11:0] short_level;
    logic [3:0]  debounce_limit;
    logic [3:0]  slow_blink_half;
    logic [4:0]  phase_last;
  } cfg_t;

  typedef struct packed {
    logic [ChanW-1:0]        channel;
    logic [AdcW-1:0]         adc_level;
    logic signed [TempW-1:0] temperature;
    logic signed [TempW-1:0] threshold;
  } sample_t;

  typedef struct packed {
    logic [ChanW-1:0] led_channel;
    logic             led_drive;
    logic             led_on;
    logic [1:0]       display_mode;
    logic             scan_done;
    logic             relay_on;
  } result_t;

  typedef struct packed {
    mode_e             mode_next;
    logic [CntW-1:0]   cnt_next;
    logic              any_over_next;
    logic              relay_next;
    logic [PhaseW-1:0] phase_next;
  } upd_t;

endpackage

// ===== hw/rtl/scls_if.sv =====
// ----------------------------------------------------------------------------
// scls_if
// Valid/ready channels of the block: sensor samples, led results and
// configuration writes.
// ----------------------------------------------------------------------------
interface scls_sample_if;
  logic                             valid;
  logic                             ready;
  logic [scls_pkg::ChanW-1:0]        channel;
  logic [scls_pkg::AdcW-1:0]         adc_level;
  logic signed [scls_pkg::TempW-1:0] temperature;
  logic signed [scls_pkg::TempW-1:0] threshold;

  modport source (output valid, channel, adc_level, temperature, threshold, input ready);
  modport sink (input valid, channel, adc_level, temperature, threshold, output ready);
endinterface

interface scls_result_if;
  logic                      valid;
  logic                      ready;
  logic [scls_pkg::ChanW-1:0] led_channel;
  logic                      led_drive;
  logic                      led_on;
  logic [1:0]                display_mode;
  logic                      scan_done;
  logic                      relay_on;

  modport source (output valid, led_channel, led_drive, led_on, display_mode, scan_done,
                  relay_on, input ready);
  modport sink (input valid, led_channel, led_drive, led_on, display_mode, scan_done,
                relay_on, output ready);
endinterface

interface scls_cfg_if;
  logic                         valid;
  logic                         ready;
  logic [scls_pkg::CfgAddrW-1:0] addr;
  logic [scls_pkg::CfgDataW-1:0] wdata;

  modport source (output valid, addr, wdata, input ready);
  modport sink (input valid, addr, wdata, output ready);
endinterface

// ===== hw/rtl/scls_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// scls_cfg_regs
// Configuration register file, written one register per transfer.
// ----------------------------------------------------------------------------
module scls_cfg_regs (
  input  logic             clk_i,
  input  logic             rst_ni,
  scls_cfg_if.sink         cfg_i,
  output scls_pkg::cfg_t   cfg_o
);

  scls_pkg::cfg_t cfg_q;

  assign cfg_i.ready = 1'b1;
  assign cfg_o       = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.open_level      <= scls_pkg::OpenLevelRst;
      cfg_q.short_level     <= scls_pkg::ShortLevelRst;
      cfg_q.debounce_limit  <= scls_pkg::DebounceLimitRst;
      cfg_q.slow_blink_half <= scls_pkg::SlowBlinkHalfRst;
      cfg_q.phase_last      <= scls_pkg::PhaseLastRst;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.addr)
        scls_pkg::CFG_OPEN_LEVEL:      cfg_q.open_level      <= cfg_i.wdata;
        scls_pkg::CFG_SHORT_LEVEL:     cfg_q.short_level     <= cfg_i.wdata;
        scls_pkg::CFG_DEBOUNCE_LIMIT:  cfg_q.debounce_limit  <= cfg_i.wdata[3:0];
        scls_pkg::CFG_SLOW_BLINK_HALF: cfg_q.slow_blink_half <= cfg_i.wdata[3:0];
        scls_pkg::CFG_PHASE_LAST:      cfg_q.phase_last      <= cfg_i.wdata[4:0];
        default: begin
        end
      endcase
    end
  end

endmodule

// ===== hw/rtl/scls_eval.sv =====
// ----------------------------------------------------------------------------
// scls_eval
// Per-channel classification, mode debounce, led blink and scan-end update.
// ----------------------------------------------------------------------------
module scls_eval (
  input  scls_pkg::sample_t               sample_i,
  input  logic                            in_range_i,
  input  logic                            last_i,
  input  scls_pkg::cfg_t                  cfg_i,
  input  scls_pkg::mode_e                 mode_i,
  input  logic [scls_pkg::CntW-1:0]       cnt_i,
  input  logic [scls_pkg::PhaseW-1:0]     phase_i,
  input  logic                            any_over_i,
  input  logic                            relay_i,
  output scls_pkg::upd_t                  upd_o,
  output scls_pkg::result_t               result_o
);

  logic                        over;
  scls_pkg::mode_e             want;
  logic                        match;
  logic [scls_pkg::CntW-1:0]   cnt_inc;
  logic                        flip;
  logic                        show;
  logic                        drive;
  logic                        led;
  logic [scls_pkg::PhaseW:0]   ph6;
  logic [scls_pkg::PhaseW:0]   half6;
  logic [scls_pkg::PhaseW:0]   full6;
  logic [scls_pkg::PhaseW:0]   ph_inc;
  logic                        any_over_set;

  always_comb begin
    over = sample_i.temperature > sample_i.threshold;
    priority if (over) begin
      want = scls_pkg::MODE_OVER;
    end else if (sample_i.adc_level > cfg_i.open_level) begin
      want = scls_pkg::MODE_OPEN;
    end else if (sample_i.adc_level < cfg_i.short_level) begin
      want = scls_pkg::MODE_SHORT;
    end else begin
      want = scls_pkg::MODE_NORMAL;
    end

    match   = (mode_i == want);
    cnt_inc = (cnt_i == scls_pkg::CntMax) ? cnt_i : cnt_i + 1'b1;
    flip    = !match && (cnt_inc > {1'b0, cfg_i.debounce_limit});
    show    = match || flip;

    ph6   = {1'b0, phase_i};
    half6 = {2'b00, cfg_i.slow_blink_half};
    full6 = {1'b0, cfg_i.slow_blink_half, 1'b0};

    drive = 1'b0;
    led   = 1'b0;
    if (show) begin
      unique case (want)
        scls_pkg::MODE_OPEN: begin
          drive = 1'b1;
          led   = 1'b1;
        end
        scls_pkg::MODE_SHORT: begin
          drive = 1'b1;
          led   = !phase_i[1];
        end
        scls_pkg::MODE_OVER: begin
          drive = ph6 < full6;
          led   = ph6 < half6;
        end
        default: begin
          drive = 1'b1;
          led   = 1'b0;
        end
      endcase
    end

    upd_o.mode_next = flip ? want : mode_i;
    upd_o.cnt_next  = match ? cnt_i : (flip ? '0 : cnt_inc);

    // scan end: latch relay, restart over flag, advance phase
    any_over_set = any_over_i || over;
    ph_inc       = ph6 + 1'b1;
    upd_o.any_over_next = any_over_i;
    upd_o.relay_next    = relay_i;
    upd_o.phase_next    = phase_i;
    if (in_range_i) begin
      upd_o.any_over_next = any_over_set;
      if (last_i) begin
        upd_o.relay_next    = any_over_set;
        upd_o.any_over_next = 1'b0;
        upd_o.phase_next    = ((ph_inc > {1'b0, cfg_i.phase_last}) || ph_inc[scls_pkg::PhaseW])
                              ? '0 : ph_inc[scls_pkg::PhaseW-1:0];
      end
    end

    result_o.led_channel  = sample_i.channel;
    result_o.led_drive    = in_range_i && drive;
    result_o.led_on       = in_range_i && led;
    result_o.display_mode = in_range_i ? upd_o.mode_next : scls_pkg::MODE_NORMAL;
    result_o.scan_done    = in_range_i && last_i;
    result_o.relay_on     = upd_o.relay_next;
  end

endmodule

// ===== hw/rtl/scls_pipe.sv =====
// ----------------------------------------------------------------------------
// scls_pipe
// Input register, per-channel state, scan state and result register.
// ----------------------------------------------------------------------------
module scls_pipe #(
  parameter int unsigned NUM_CHANNELS = scls_pkg::NumChannels
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  scls_pkg::cfg_t  cfg_i,
  scls_sample_if.sink     sample_i,
  scls_result_if.source   result_o
);

  localparam int unsigned IdxW = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

  logic                          in_valid_q;
  scls_pkg::sample_t             in_q;
  logic                          res_valid_q;
  scls_pkg::result_t             res_q;
  scls_pkg::mode_e               mode_q [NUM_CHANNELS];
  logic [scls_pkg::CntW-1:0]     cnt_q  [NUM_CHANNELS];
  logic [scls_pkg::PhaseW-1:0]   phase_q;
  logic                          any_over_q;
  logic                          relay_q;

  logic                          adv;
  logic                          take;
  logic [7:0]                    ch_ext;
  logic [IdxW-1:0]               idx;
  logic                          in_range;
  logic                          last;
  scls_pkg::upd_t                upd;
  scls_pkg::result_t             res_d;

  assign adv            = in_valid_q && (!res_valid_q || result_o.ready);
  assign sample_i.ready = !in_valid_q || adv;
  assign take           = sample_i.valid && sample_i.ready;

  assign ch_ext   = {4'b0000, in_q.channel};
  assign idx      = ch_ext[IdxW-1:0];
  assign in_range = ch_ext < 8'(NUM_CHANNELS);
  assign last     = ch_ext == 8'(NUM_CHANNELS - 1);

  scls_eval u_eval (
    .sample_i   (in_q),
    .in_range_i (in_range),
    .last_i     (last),
    .cfg_i      (cfg_i),
    .mode_i     (mode_q[idx]),
    .cnt_i      (cnt_q[idx]),
    .phase_i    (phase_q),
    .any_over_i (any_over_q),
    .relay_i    (relay_q),
    .upd_o      (upd),
    .result_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (take) begin
      in_valid_q <= 1'b1;
    end else if (adv) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      in_q.channel     <= sample_i.channel;
      in_q.adc_level   <= sample_i.adc_level;
      in_q.temperature <= sample_i.temperature;
      in_q.threshold   <= sample_i.threshold;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (adv) begin
      res_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      res_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CHANNELS; i++) begin
        mode_q[i] <= scls_pkg::MODE_NORMAL;
        cnt_q[i]  <= '0;
      end
      phase_q    <= '0;
      any_over_q <= 1'b0;
      relay_q    <= 1'b0;
    end else if (adv) begin
      if (in_range) begin
        mode_q[idx] <= upd.mode_next;
        cnt_q[idx]  <= upd.cnt_next;
      end
      phase_q    <= upd.phase_next;
      any_over_q <= upd.any_over_next;
      relay_q    <= upd.relay_next;
    end
  end

  assign result_o.valid        = res_valid_q;
  assign result_o.led_channel  = res_q.led_channel;
  assign result_o.led_drive    = res_q.led_drive;
  assign result_o.led_on       = res_q.led_on;
  assign result_o.display_mode = res_q.display_mode;
  assign result_o.scan_done    = res_q.scan_done;
  assign result_o.relay_on     = res_q.relay_on;

  a_adv_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> res_valid_q)
    else $error("advanced item did not reach result register");

  a_take_fills_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take |=> in_valid_q)
    else $error("accepted sample not held in input register");

  a_relay_at_scan_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(relay_q) |-> $past(adv && in_range && last))
    else $error("relay changed outside scan end");

  a_over_flag_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_range && last) |=> !any_over_q)
    else $error("over flag not cleared at scan end");

  a_relay_shown: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> (res_q.relay_on == relay_q))
    else $error("result relay differs from relay state");

endmodule

// ===== hw/rtl/sensor_channel_led_status_top.sv =====
// ----------------------------------------------------------------------------
// sensor_channel_led_status_top
// Sensor channel classifier with debounced led display modes and alarm relay.
// ----------------------------------------------------------------------------
// path: a sample is held in the input register, then its result is offered
// from the result register; a stalled result holds the sample in place
// throughput: one sample per cycle while result ready is high, set by the
// single state read-modify-write per item between input and result register
// reset: asynchronous, clears all modes, counts, phase, over flag and relay,
// and loads the configuration defaults; usable as soon as reset is released
module sensor_channel_led_status_top #(
  parameter int unsigned NUM_CHANNELS = scls_pkg::NumChannels
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  scls_cfg_if.sink       cfg_i,
  scls_sample_if.sink    sample_i,
  scls_result_if.source  result_o
);

  scls_pkg::cfg_t cfg;

  scls_cfg_regs u_cfg_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  scls_pipe #(
    .NUM_CHANNELS (NUM_CHANNELS)
  ) u_pipe (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .sample_i (sample_i),
    .result_o (result_o)
  );

endmodule
